### rtl/core/incremental_pi_motor_speed_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the PI motor speed block
// Shared property forms; each use names its own clock, reset and signals.
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_PI_MOTOR_SPEED_DEFINES_SVH
`define INCREMENTAL_PI_MOTOR_SPEED_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define IPMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define IPMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

### rtl/core/ipms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipms_pkg
// Types, register codes and reset values for the PI motor speed block.
// ----------------------------------------------------------------------------
package ipms_pkg;

	localparam int GAIN_FRAC_BITS_DEF = 8;

	localparam int TARGET_W = 16;
	localparam int GAIN_W   = 16;
	localparam int LIMIT_W  = 12;
	localparam int DELTA_W  = 16;
	localparam int ERR_W    = 17;
	localparam int DIFF_W   = 18;
	localparam int PROD_W   = 35;
	localparam int SUM_W    = 36;
	localparam int DRIVE_W  = 13;
	localparam int DUTY_W   = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 2'd3;

	localparam logic [TARGET_W-1:0] TARGET_RST      = 16'd0;
	localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 16'd11520;
	localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST  = 16'd768;
	localparam logic [LIMIT_W-1:0]  DRIVE_LIMIT_RST = 12'd999;

	typedef struct packed {
		logic [TARGET_W-1:0] target_pulses;
		logic [GAIN_W-1:0]   prop_gain;
		logic [GAIN_W-1:0]   integ_gain;
		logic [LIMIT_W-1:0]  drive_limit;
	} cfg_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic              run;
		logic [PROD_W-1:0] p_term;
		logic [PROD_W-1:0] i_term;
	} prod_t;

endpackage

### rtl/core/ipms_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipms_cfg_regs
// Configuration register file: target, gains and drive limit.
// ----------------------------------------------------------------------------
module ipms_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ipms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ipms_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ipms_pkg::cfg_t                      cfg
);
	import ipms_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_pulses <= TARGET_RST;
			cfg_q.prop_gain     <= PROP_GAIN_RST;
			cfg_q.integ_gain    <= INTEG_GAIN_RST;
			cfg_q.drive_limit   <= DRIVE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET:      cfg_q.target_pulses <= cfg_data[TARGET_W-1:0];
				REG_PROP_GAIN:   cfg_q.prop_gain     <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:  cfg_q.integ_gain    <= cfg_data[GAIN_W-1:0];
				REG_DRIVE_LIMIT: cfg_q.drive_limit   <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/ipms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipms_front
// Error, error change and gain products; holds the previous error.
// ----------------------------------------------------------------------------
module ipms_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ipms_pkg::ctl_t                      ctl,
	input  ipms_pkg::cfg_t                      cfg,
	input  logic signed [ipms_pkg::DELTA_W-1:0] encoder_delta,
	output ipms_pkg::prod_t                     prod_s2
);
	import ipms_pkg::*;

	logic signed [DELTA_W-1:0] delta_s1;
	logic                      run_s1;
	logic signed [ERR_W-1:0]   last_error_q;
	logic signed [ERR_W-1:0]   err;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PROD_W-1:0]  p_mul;
	logic signed [PROD_W-1:0]  i_mul;
	prod_t                     prod_q;

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			delta_s1 <= encoder_delta;
			run_s1   <= (cfg.target_pulses != '0);
		end
	end

	assign err  = ERR_W'($signed(cfg.target_pulses)) - ERR_W'(delta_s1);
	assign diff = DIFF_W'(err) - DIFF_W'(last_error_q);

	assign p_mul = PROD_W'($signed({1'b0, cfg.prop_gain})) * PROD_W'(diff);
	assign i_mul = PROD_W'($signed({1'b0, cfg.integ_gain})) * PROD_W'(err);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
		end else if (ctl.load_s2 && run_s1) begin
			last_error_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			prod_q.run    <= run_s1;
			prod_q.p_term <= p_mul;
			prod_q.i_term <= i_mul;
		end
	end

	assign prod_s2 = prod_q;

endmodule

### rtl/core/ipms_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipms_drive
// Truncate the increment, accumulate and saturate the drive, set the bridge.
// ----------------------------------------------------------------------------
module ipms_drive #(
	parameter int GAIN_FRAC_BITS = ipms_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ipms_pkg::ctl_t                       ctl,
	input  ipms_pkg::cfg_t                       cfg,
	input  ipms_pkg::prod_t                      prod_s2,
	output logic [ipms_pkg::DUTY_W-1:0]          duty,
	output logic                                 bridge_in1,
	output logic                                 bridge_in2,
	output logic signed [ipms_pkg::DRIVE_W-1:0]  signed_drive
);
	import ipms_pkg::*;

	localparam int ACC_W = SUM_W + 1;
	localparam logic [SUM_W-1:0] ROUND_BIAS = (SUM_W'(1) << GAIN_FRAC_BITS) - SUM_W'(1);

	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   sum_adj;
	logic signed [SUM_W-1:0]   incr;
	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   lim_pos;
	logic signed [ACC_W-1:0]   lim_neg;
	logic signed [DRIVE_W-1:0] acc_sat;
	logic signed [DRIVE_W-1:0] acc_abs;
	logic signed [DRIVE_W-1:0] drive_accum_q;

	assign sum     = SUM_W'($signed(prod_s2.p_term)) + SUM_W'($signed(prod_s2.i_term));
	assign sum_adj = sum + (sum[SUM_W-1] ? $signed(ROUND_BIAS) : $signed(SUM_W'(0)));
	assign incr    = sum_adj >>> GAIN_FRAC_BITS;
	assign acc     = ACC_W'(incr) + ACC_W'(drive_accum_q);
	assign lim_pos = $signed({{(ACC_W-LIMIT_W){1'b0}}, cfg.drive_limit});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (acc > lim_pos) begin
			acc_sat = DRIVE_W'(lim_pos);
		end else if (acc < lim_neg) begin
			acc_sat = DRIVE_W'(lim_neg);
		end else begin
			acc_sat = DRIVE_W'(acc);
		end
	end

	assign acc_abs = acc_sat[DRIVE_W-1] ? -acc_sat : acc_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_accum_q <= '0;
		end else if (ctl.load_out) begin
			drive_accum_q <= prod_s2.run ? acc_sat : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			if (prod_s2.run) begin
				duty         <= acc_abs[DUTY_W-1:0];
				bridge_in1   <= ~acc_sat[DRIVE_W-1];
				bridge_in2   <= acc_sat[DRIVE_W-1];
				signed_drive <= acc_sat;
			end else begin
				duty         <= '0;
				bridge_in1   <= 1'b0;
				bridge_in2   <= 1'b0;
				signed_drive <= '0;
			end
		end
	end

endmodule

### rtl/core/incremental_pi_motor_speed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pi_motor_speed
// Velocity-form PI speed loop: encoder pulse count in, H-bridge pins and duty out.
// ----------------------------------------------------------------------------
// Takes one encoder pulse count per transaction and returns one result per
// transaction. A new transaction is accepted every cycle while in_stall is
// low: the first stage forms the error and its change, the
// second holds the two gain products, and the third closes the drive
// accumulator loop and saturates it. While target_pulses is zero each result
// reports a stopped motor and clears the accumulator; the previous error is kept.
module incremental_pi_motor_speed #(
	parameter int GAIN_FRAC_BITS = ipms_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ipms_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ipms_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [ipms_pkg::DELTA_W-1:0]  encoder_delta,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ipms_pkg::DUTY_W-1:0]          duty,
	output logic                                 bridge_in1,
	output logic                                 bridge_in2,
	output logic signed [ipms_pkg::DRIVE_W-1:0]  signed_drive
);
	import ipms_pkg::*;

`include "incremental_pi_motor_speed_defines.svh"

	cfg_t  cfg;
	ctl_t  ctl;
	prod_t prod_s2;
	logic  valid_s1;
	logic  valid_s2;
	logic  out_valid_q;
	logic  free_s1;
	logic  free_s2;

	assign ctl.load_out = valid_s2 && (!out_valid_q || !out_stall);
	assign free_s2      = !valid_s2 || ctl.load_out;
	assign ctl.load_s2  = valid_s1 && free_s2;
	assign free_s1      = !valid_s1 || ctl.load_s2;
	assign ctl.load_s1  = in_valid && free_s1;
	assign in_stall     = !free_s1;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load_s1) begin
				valid_s1 <= 1'b1;
			end else if (ctl.load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (ctl.load_s2) begin
				valid_s2 <= 1'b1;
			end else if (ctl.load_out) begin
				valid_s2 <= 1'b0;
			end
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= ctl.load_out;
			end
		end
	end

	ipms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ipms_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cfg           (cfg),
		.encoder_delta (encoder_delta),
		.prod_s2       (prod_s2)
	);

	ipms_drive #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_drive (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cfg          (cfg),
		.prod_s2      (prod_s2),
		.duty         (duty),
		.bridge_in1   (bridge_in1),
		.bridge_in2   (bridge_in2),
		.signed_drive (signed_drive)
	);

	`IPMS_ASSERT_SAME(a_pins_exclusive, clk, arst_n, out_valid_q, !(bridge_in1 && bridge_in2))
	`IPMS_ASSERT_SAME(a_stop_is_zero, clk, arst_n, out_valid_q && !bridge_in1 && !bridge_in2,
		duty == '0 && signed_drive == '0)
	`IPMS_ASSERT_SAME(a_reverse_sign, clk, arst_n, out_valid_q && bridge_in2,
		signed_drive[DRIVE_W-1] && duty != '0)
	`IPMS_ASSERT_SAME(a_stall_only_full, clk, arst_n, in_stall, valid_s1 && valid_s2 && out_valid_q)
	`IPMS_ASSERT_NEXT(a_result_follows, clk, arst_n, ctl.load_out, out_valid_q)

endmodule
